@@ hw/rtl/rgbc_pkg.sv @@
// Package for the RGB 3x3 convolution block: sizes, register codes and the
// types passed between its stages. No dependencies.
`timescale 1ns / 1ps

package rgbc_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 16;
    localparam int COEF_W       = 16;
    localparam int KROW_W       = 3 * COEF_W;
    localparam int CH_W         = 8;
    localparam int PIX_W        = 3 * CH_W;
    localparam int TAPS         = 9;
    localparam int FRAC_W       = 12;
    localparam int PROD_W       = CH_W + 1 + COEF_W;
    localparam int RSUM_W       = PROD_W + 2;
    localparam int TOTAL_W      = RSUM_W + 2;
    localparam int CFG_DATA_W   = KROW_W;

    localparam logic [CH_W-1:0] PIX_MAX = 8'd255;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd768;
    localparam logic [KROW_W-1:0]       KTOP_RESET   = 48'h0000_0000_0000;
    localparam logic [KROW_W-1:0]       KMID_RESET   = 48'h0000_1000_0000;
    localparam logic [KROW_W-1:0]       KBOT_RESET   = 48'h0000_0000_0000;

    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_KERNEL_TOP    = 3'd2,
        CFG_KERNEL_MIDDLE = 3'd3,
        CFG_KERNEL_BOTTOM = 3'd4
    } cfg_index_t;

    // One pixel leaving the line store stage, with its column neighbours above.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] px;
        logic             emit;
        logic             last;
    } line_item_t;

    typedef logic [TAPS-1:0][PIX_W-1:0] window_t;
    typedef logic [2:0][KROW_W-1:0]     kernel_t;

endpackage

@@ hw/rtl/rgbc_line_buf.sv @@
// Line store for the RGB 3x3 convolution: column/row counters and a
// synchronous memory holding the two previous rows. Uses rgbc_pkg.
`timescale 1ns / 1ps

module rgbc_line_buf (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [rgbc_pkg::WIDTH_REG_W-1:0]  image_width,
    input  logic [rgbc_pkg::HEIGHT_REG_W-1:0] image_height,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rgbc_pkg::PIX_W-1:0]        in_pixel,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rgbc_pkg::line_item_t              out_item
);

    // Entry c: [2*PIX_W-1:PIX_W] is row r-2, [PIX_W-1:0] is row r-1.
    logic [2*rgbc_pkg::PIX_W-1:0] mem [rgbc_pkg::MAX_WIDTH];

    logic [rgbc_pkg::COL_W-1:0]        col_reg, col_next;
    logic [rgbc_pkg::HEIGHT_REG_W-1:0] row_reg, row_next;
    logic                              v1_reg;
    logic [rgbc_pkg::COL_W-1:0]        addr1_reg;
    logic [rgbc_pkg::PIX_W-1:0]        px1_reg;
    logic                              emit1_reg, last1_reg;
    logic [2*rgbc_pkg::PIX_W-1:0]      rd_reg;

    logic [rgbc_pkg::WIDTH_REG_W-1:0]  w_eff;
    logic [rgbc_pkg::COL_W-1:0]        wm1;
    logic [rgbc_pkg::HEIGHT_REG_W-1:0] hm1;
    logic                              acc, row_end, last, emit, drain;

    assign in_ready = !v1_reg || out_ready;
    assign acc      = in_valid && in_ready;
    assign drain    = v1_reg && out_ready;

    always_comb begin
        if (image_width < rgbc_pkg::WIDTH_REG_W'(3)) begin
            w_eff = rgbc_pkg::WIDTH_REG_W'(3);
        end else if (image_width > rgbc_pkg::WIDTH_REG_W'(rgbc_pkg::MAX_WIDTH)) begin
            w_eff = rgbc_pkg::WIDTH_REG_W'(rgbc_pkg::MAX_WIDTH);
        end else begin
            w_eff = image_width;
        end
        wm1 = rgbc_pkg::COL_W'(w_eff - rgbc_pkg::WIDTH_REG_W'(1));
        if (image_height < rgbc_pkg::HEIGHT_REG_W'(3)) begin
            hm1 = rgbc_pkg::HEIGHT_REG_W'(2);
        end else begin
            hm1 = image_height - rgbc_pkg::HEIGHT_REG_W'(1);
        end
        row_end = col_reg >= wm1;
        last    = row_end && (row_reg >= hm1);
        emit    = (row_reg >= rgbc_pkg::HEIGHT_REG_W'(2)) && (col_reg >= rgbc_pkg::COL_W'(2));
        if (row_end) begin
            col_next = '0;
            row_next = last ? '0 : row_reg + rgbc_pkg::HEIGHT_REG_W'(1);
        end else begin
            col_next = col_reg + rgbc_pkg::COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
        end else begin
            if (acc) begin
                col_reg <= col_next;
                row_reg <= row_next;
                v1_reg  <= 1'b1;
            end else if (out_ready) begin
                v1_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            addr1_reg <= col_reg;
            px1_reg   <= in_pixel;
            emit1_reg <= emit;
            last1_reg <= last;
        end
    end

    // Consecutive pixels always address different columns, so the read of
    // the new pixel never meets the write-back of the previous one.
    always_ff @(posedge aclk) begin
        if (acc) begin
            rd_reg <= mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (drain) begin
            mem[addr1_reg] <= {rd_reg[rgbc_pkg::PIX_W-1:0], px1_reg};
        end
    end

    assign out_valid     = v1_reg;
    assign out_item.top  = rd_reg[2*rgbc_pkg::PIX_W-1:rgbc_pkg::PIX_W];
    assign out_item.mid  = rd_reg[rgbc_pkg::PIX_W-1:0];
    assign out_item.px   = px1_reg;
    assign out_item.emit = emit1_reg;
    assign out_item.last = last1_reg;

endmodule

@@ hw/rtl/rgbc_window.sv @@
// 3x3 pixel window for the RGB convolution: shifts in one column per pixel
// and presents it for interior pixels. Uses rgbc_pkg.
`timescale 1ns / 1ps

module rgbc_window (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rgbc_pkg::line_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rgbc_pkg::window_t    out_window,
    output logic                 out_last
);

    rgbc_pkg::window_t win_reg;
    logic              v2_reg, last2_reg;
    logic              take;

    assign in_ready = !v2_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   <= '0;
            v2_reg    <= 1'b0;
            last2_reg <= 1'b0;
        end else begin
            if (take) begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= in_item.top;
                win_reg[3] <= win_reg[4];
                win_reg[4] <= win_reg[5];
                win_reg[5] <= in_item.mid;
                win_reg[6] <= win_reg[7];
                win_reg[7] <= win_reg[8];
                win_reg[8] <= in_item.px;
                // border pixels update the window but leave no item behind
                v2_reg     <= in_item.emit;
                last2_reg  <= in_item.last;
            end else if (out_ready) begin
                v2_reg     <= 1'b0;
            end
        end
    end

    assign out_valid  = v2_reg;
    assign out_window = win_reg;
    assign out_last   = last2_reg;

endmodule

@@ hw/rtl/rgbc_filter.sv @@
// Multiply-accumulate and clamp for the RGB convolution: 27 products, row
// sums, final sum with truncation and 0..255 clamp, output register. Uses rgbc_pkg.
`timescale 1ns / 1ps

module rgbc_filter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  rgbc_pkg::window_t           in_window,
    input  logic                        in_last,
    input  rgbc_pkg::kernel_t           kernel,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rgbc_pkg::PIX_W-1:0]  m_tdata,
    output logic                        m_tlast
);

    logic [rgbc_pkg::TAPS-1:0][rgbc_pkg::COEF_W-1:0]        coef;
    logic [2:0][rgbc_pkg::TAPS-1:0][rgbc_pkg::PROD_W-1:0]   prod_reg;
    logic [2:0][2:0][rgbc_pkg::RSUM_W-1:0]                  rsum_reg;
    logic [2:0][rgbc_pkg::TOTAL_W-1:0]                      total;
    logic [2:0][rgbc_pkg::CH_W-1:0]                         clamped;
    logic v3_reg, v4_reg, mv_reg;
    logic last3_reg, last4_reg, mlast_reg;
    logic [rgbc_pkg::PIX_W-1:0] mdata_reg;
    logic r4, r5;

    for (genvar t = 0; t < rgbc_pkg::TAPS; t++) begin : g_coef
        assign coef[t] = kernel[t / 3][rgbc_pkg::COEF_W * (t % 3) +: rgbc_pkg::COEF_W];
    end

    assign r5       = !mv_reg || m_tready;
    assign r4       = !v4_reg || r5;
    assign in_ready = !v3_reg || r4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                v3_reg <= 1'b1;
            end else if (r4) begin
                v3_reg <= 1'b0;
            end
            if (v3_reg && r4) begin
                v4_reg <= 1'b1;
            end else if (r5) begin
                v4_reg <= 1'b0;
            end
            if (v4_reg && r5) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            for (int ch = 0; ch < 3; ch++) begin
                for (int t = 0; t < rgbc_pkg::TAPS; t++) begin
                    prod_reg[ch][t] <= $signed({1'b0, in_window[t][rgbc_pkg::CH_W * ch +: rgbc_pkg::CH_W]})
                                     * $signed(coef[t]);
                end
            end
            last3_reg <= in_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (v3_reg && r4) begin
            for (int ch = 0; ch < 3; ch++) begin
                for (int r = 0; r < 3; r++) begin
                    rsum_reg[ch][r] <= rgbc_pkg::RSUM_W'($signed(prod_reg[ch][3 * r]))
                                     + rgbc_pkg::RSUM_W'($signed(prod_reg[ch][3 * r + 1]))
                                     + rgbc_pkg::RSUM_W'($signed(prod_reg[ch][3 * r + 2]));
                end
            end
            last4_reg <= last3_reg;
        end
    end

    // A negative sum truncates toward zero and then clamps to 0 either way,
    // so only non-negative sums need the fraction dropped.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            total[ch] = rgbc_pkg::TOTAL_W'($signed(rsum_reg[ch][0]))
                      + rgbc_pkg::TOTAL_W'($signed(rsum_reg[ch][1]))
                      + rgbc_pkg::TOTAL_W'($signed(rsum_reg[ch][2]));
            if (total[ch][rgbc_pkg::TOTAL_W-1]) begin
                clamped[ch] = '0;
            end else if (|total[ch][rgbc_pkg::TOTAL_W-2:rgbc_pkg::FRAC_W+rgbc_pkg::CH_W]) begin
                clamped[ch] = rgbc_pkg::PIX_MAX;
            end else begin
                clamped[ch] = total[ch][rgbc_pkg::FRAC_W +: rgbc_pkg::CH_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (v4_reg && r5) begin
            mdata_reg <= clamped;
            mlast_reg <= last4_reg;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

endmodule

@@ hw/rtl/rgb_conv3x3_clamp.sv @@
// A pixel passes through the line store, window, product, row-sum and output registers to m_tvalid.
// Throughput: one pixel per cycle unless m_tready stalls; the line store takes one read and one
// write-back per pixel, and the multiply-add path is split into three stages.
// Reset (aresetn low, synchronous): counters, window and valids cleared, the
// registers return to their defaults; the line store is not cleared.
`timescale 1ns / 1ps

module rgb_conv3x3_clamp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rgbc_pkg::PIX_W-1:0]       s_tdata,   // red_in, green_in, blue_in
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rgbc_pkg::PIX_W-1:0]       m_tdata,   // red_out, green_out, blue_out
    output logic                             m_tlast,   // frame_last
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [2:0]                       cfg_index,
    input  logic [rgbc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [rgbc_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [rgbc_pkg::HEIGHT_REG_W-1:0] height_reg;
    rgbc_pkg::kernel_t                 kernel_reg;

    logic                 li_valid, li_ready;
    rgbc_pkg::line_item_t li_item;
    logic                 win_valid, win_ready, win_last;
    rgbc_pkg::window_t    win_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= rgbc_pkg::WIDTH_RESET;
            height_reg    <= rgbc_pkg::HEIGHT_RESET;
            kernel_reg[0] <= rgbc_pkg::KTOP_RESET;
            kernel_reg[1] <= rgbc_pkg::KMID_RESET;
            kernel_reg[2] <= rgbc_pkg::KBOT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rgbc_pkg::CFG_IMAGE_WIDTH:   width_reg     <= cfg_data[rgbc_pkg::WIDTH_REG_W-1:0];
                rgbc_pkg::CFG_IMAGE_HEIGHT:  height_reg    <= cfg_data[rgbc_pkg::HEIGHT_REG_W-1:0];
                rgbc_pkg::CFG_KERNEL_TOP:    kernel_reg[0] <= cfg_data;
                rgbc_pkg::CFG_KERNEL_MIDDLE: kernel_reg[1] <= cfg_data;
                rgbc_pkg::CFG_KERNEL_BOTTOM: kernel_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    rgbc_line_buf u_line_buf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .image_width  (width_reg),
        .image_height (height_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_pixel     (s_tdata),
        .out_valid    (li_valid),
        .out_ready    (li_ready),
        .out_item     (li_item)
    );

    rgbc_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (li_valid),
        .in_ready   (li_ready),
        .in_item    (li_item),
        .out_valid  (win_valid),
        .out_ready  (win_ready),
        .out_window (win_data),
        .out_last   (win_last)
    );

    rgbc_filter u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (win_valid),
        .in_ready  (win_ready),
        .in_window (win_data),
        .in_last   (win_last),
        .kernel    (kernel_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // the final pixel of a frame is always an interior one
    a_last_is_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        (li_valid && li_item.last) |-> li_item.emit)
        else $error("frame end flagged on a border pixel");

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> li_valid)
        else $error("accepted pixel missing from line store stage");

    a_line_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (li_valid && !li_ready) |=> (li_valid && $stable(li_item)))
        else $error("line store stage dropped or changed a stalled pixel");

    a_window_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (win_valid && !win_ready) |=> (win_valid && $stable(win_data)))
        else $error("window changed while stalled");
`endif

endmodule
